@@ sv/idle_timeout_table_macros.svh @@
// Assertion macros used by the checker file of the idle timeout table.
`ifndef IDLE_TIMEOUT_TABLE_MACROS_SVH
`define IDLE_TIMEOUT_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITT_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/itt_pkg.sv @@
// Package of types, constants and codes for the idle timeout table.
package itt_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam int          TIMEOUT_W     = 16;
    localparam logic [15:0] TIMEOUT_RESET = 16'd30;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_UPDATE = 2'd2;
    localparam logic [1:0] REQ_SWEEP  = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_RANGE      = 3'd1;
    localparam logic [2:0] ST_NOT_IN_USE = 3'd2;
    localparam logic [2:0] ST_EXPIRED    = 3'd3;
    localparam logic [2:0] ST_NONE       = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SW_READ,
        S_SW_CHECK,
        S_SW_DONE
    } itt_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;   // a request is accepted this cycle
        logic rd_en;  // read the timestamp of the slot under scan
        logic chk;    // judge the slot under scan and step on
        logic fin;    // close the sweep with its final result
    } itt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_sweep;
        logic expired;
        logic pend_valid;
        logic scan_last;
        logic out_free;
    } itt_stat_t;

endpackage

@@ sv/itt_controller.sv @@
// Controller state machine that sequences requests and sweeps of the idle timeout table.
module itt_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  itt_pkg::itt_stat_t  stat,
    output itt_pkg::itt_cmd_t   cmd
);
    import itt_pkg::*;

    itt_state_t state_reg;
    itt_state_t state_next;
    logic       take;

    assign take = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take && stat.req_sweep)
                begin
                    state_next = S_SW_READ;
                end
            end
            S_SW_READ:
            begin
                state_next = S_SW_CHECK;
            end
            S_SW_CHECK:
            begin
                // A second expiry cannot overwrite the held one until the output is free.
                if (!(stat.expired && stat.pend_valid && !stat.out_free))
                begin
                    state_next = stat.scan_last ? S_SW_DONE : S_SW_READ;
                end
            end
            S_SW_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = stat.out_free;
                cmd.take = take;
            end
            S_SW_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            S_SW_CHECK:
            begin
                cmd.chk = !(stat.expired && stat.pend_valid && !stat.out_free);
            end
            S_SW_DONE:
            begin
                cmd.fin = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/itt_datapath.sv @@
// Datapath of the idle timeout table: slot marks, timestamp memory, scan and output register.
module itt_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  itt_pkg::itt_cmd_t   cmd,
    output itt_pkg::itt_stat_t  stat,
    input  logic [1:0]          req_type,
    input  logic [7:0]          slot_index,
    input  logic [31:0]         time_now,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [2:0]          status,
    output logic [5:0]          result_index,
    output logic                last_in_run
);
    import itt_pkg::*;

    logic [TIMEOUT_W-1:0]  timeout_reg;
    logic [SLOT_COUNT-1:0] in_use_reg;
    logic [SLOT_COUNT-1:0] in_use_next;
    logic [31:0]           ts_mem [SLOT_COUNT];
    logic [31:0]           rd_data_reg;
    logic [31:0]           now_reg;
    logic [SLOT_W-1:0]     scan_idx_reg;
    logic                  pend_valid_reg;
    logic [SLOT_W-1:0]     pend_idx_reg;
    logic                  out_valid_reg;
    logic [2:0]            out_status_reg;
    logic [5:0]            out_idx_reg;
    logic                  out_last_reg;

    logic              idx_ok;
    logic [SLOT_W-1:0] slot;
    logic              single;
    logic              sweep_start;
    logic              ts_we;
    logic [31:0]       age;
    logic              expired;
    logic              scan_last;
    logic              out_free;

    assign idx_ok      = slot_index < 8'(SLOT_COUNT);
    assign slot        = slot_index[SLOT_W-1:0];
    assign single      = cmd.take && (req_type != REQ_SWEEP);
    assign sweep_start = cmd.take && (req_type == REQ_SWEEP);
    assign ts_we       = single && idx_ok
                         && ((req_type == REQ_INSERT)
                             || ((req_type == REQ_UPDATE) && in_use_reg[slot]));
    // Age wraps modulo 2^32, so a stamp in the future reads as a very large age.
    assign age         = now_reg - rd_data_reg;
    assign expired     = in_use_reg[scan_idx_reg] && (age >= {16'd0, timeout_reg});
    assign scan_last   = scan_idx_reg == SLOT_W'(SLOT_COUNT - 1);
    assign out_free    = !out_valid_reg || out_ready;

    assign stat.req_sweep  = req_type == REQ_SWEEP;
    assign stat.expired    = expired;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.scan_last  = scan_last;
    assign stat.out_free   = out_free;

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign result_index = out_idx_reg;
    assign last_in_run  = out_last_reg;

    always_comb
    begin
        in_use_next = in_use_reg;
        if (single && idx_ok && (req_type == REQ_INSERT))
        begin
            in_use_next[slot] = 1'b1;
        end
        if (single && idx_ok && (req_type == REQ_DELETE))
        begin
            in_use_next[slot] = 1'b0;
        end
        if (cmd.chk && expired)
        begin
            in_use_next[scan_idx_reg] = 1'b0;
        end
    end

    // A free slot's timestamp is read but ignored, so freeing needs no memory write.
    always_ff @(posedge clk)
    begin
        if (ts_we)
        begin
            ts_mem[slot] <= time_now;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= ts_mem[scan_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= TIMEOUT_RESET;
            in_use_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            in_use_reg <= in_use_next;
            if (sweep_start)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.chk && expired)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (single || (cmd.chk && expired && pend_valid_reg) || cmd.fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sweep_start)
        begin
            now_reg      <= time_now;
            scan_idx_reg <= '0;
        end
        else if (cmd.chk && !scan_last)
        begin
            scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
        end
        if (cmd.chk && expired)
        begin
            pend_idx_reg <= scan_idx_reg;
        end

        priority if (single)
        begin
            out_last_reg <= 1'b1;
            if (!idx_ok)
            begin
                out_status_reg <= ST_RANGE;
                out_idx_reg    <= '0;
            end
            else
            begin
                out_idx_reg <= 6'(slot);
                if ((req_type == REQ_UPDATE) && !in_use_reg[slot])
                begin
                    out_status_reg <= ST_NOT_IN_USE;
                end
                else
                begin
                    out_status_reg <= ST_OK;
                end
            end
        end
        else if (cmd.chk && expired && pend_valid_reg)
        begin
            // A later expiry proves the held one is not the last of the run.
            out_status_reg <= ST_EXPIRED;
            out_idx_reg    <= 6'(pend_idx_reg);
            out_last_reg   <= 1'b0;
        end
        else if (cmd.fin)
        begin
            out_last_reg <= 1'b1;
            if (pend_valid_reg)
            begin
                out_status_reg <= ST_EXPIRED;
                out_idx_reg    <= 6'(pend_idx_reg);
            end
            else
            begin
                out_status_reg <= ST_NONE;
                out_idx_reg    <= '0;
            end
        end
        else
        begin
            out_last_reg <= out_last_reg;
        end
    end

endmodule

@@ sv/idle_timeout_table.sv @@
// Idle timeout table: a table of connection slots with last-activity stamps and ageing sweeps.
//
// A request enters on in_valid/in_ready with req_type, slot_index and time_now; results leave
// on out_valid/out_ready with status, result_index and last_in_run. The timeout in seconds is
// written through cfg_we/cfg_wdata and resets to 30; the user must write it only while the block
// is idle, which the block itself does not enforce. Insert, delete and update give one result,
// registered in the cycle after the request is taken; a new request can be taken every cycle
// while results are drained promptly. A sweep reads each slot's stamp from a single-port
// timestamp memory, one read and one compare per slot. Expired slots are reported in ascending
// order; each report is held back until the next expiry or the end of the scan so that the final
// one carries last_in_run. A sweep with no expiry gives one "nothing expired" result.
// Results sit in an output register; when the receiver stalls, the register holds its
// result, and the sweep pauses when a second expiry or the final result must wait for it.
// After reset every slot is free, the output is empty and no clearing pass is needed.
module idle_timeout_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  slot_index,
    input  logic [31:0] time_now,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [5:0]  result_index,
    output logic        last_in_run,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import itt_pkg::*;

    itt_cmd_t  cmd;
    itt_stat_t stat;

    itt_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    itt_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (req_type),
        .slot_index   (slot_index),
        .time_now     (time_now),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .status       (status),
        .result_index (result_index),
        .last_in_run  (last_in_run)
    );

endmodule

@@ sv/itt_checker.sv @@
// Port checker for the idle timeout table and its bind to the top level.
`include "idle_timeout_table_macros.svh"

module itt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [5:0]  result_index,
    input logic        last_in_run
);
    import itt_pkg::*;

    `ITT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(result_index) && $stable(last_in_run), "stalled result changed")
    `ITT_ASSERT_SAME(a_single_last, out_valid && (status == ST_OK || status == ST_NOT_IN_USE || status == ST_RANGE || status == ST_NONE), last_in_run, "single result without last mark")
    `ITT_ASSERT_SAME(a_zero_index, out_valid && (status == ST_RANGE || status == ST_NONE), result_index == 6'd0, "range or none result with nonzero index")
    `ITT_ASSERT_SAME(a_ready_free, in_ready, !out_valid || out_ready, "request taken while output is blocked")

endmodule

bind idle_timeout_table itt_checker u_itt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .result_index (result_index),
    .last_in_run  (last_in_run)
);
